[design/pmc_pkg.sv]
// Package for the polynomial multiply core: sizes, request types, controller state,
// and the command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package pmc_pkg;

  // Capacity and coefficient precision
  localparam int MAX_TERMS  = 32;
  localparam int COEFF_BITS = 16;

  // Fixed field widths of the requests
  localparam int COEFF_W   = 16;
  localparam int SUM_OUT_W = 37;
  localparam int DEG_W     = 6;

  // Derived sizes
  localparam int EFF_BITS  = (COEFF_BITS < COEFF_W) ? COEFF_BITS : COEFF_W;
  localparam int EXT_SHIFT = COEFF_W - EFF_BITS;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int K_W       = (MAX_TERMS > 1) ? $clog2(2 * MAX_TERMS - 1) : 1;
  localparam int TOT_W     = K_W + 1;
  localparam int PROD_W    = 2 * COEFF_W;

  // Input request: one coefficient
  typedef struct packed {
    logic                      func;
    logic signed [COEFF_W-1:0] coeff;
    logic                      last;
  } in_req_t;

  // Output request: one product coefficient
  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] product_coeff;
    logic [DEG_W-1:0]            degree;
    logic                        last_out;
    logic                        dropped;
  } out_req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_DEG,
    ST_MAC,
    ST_ZERO,
    ST_CLEAR
  } pmc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              load_open;
    logic              issue;
    logic              first;
    logic              term_last;
    logic              final_term;
    logic [K_W-1:0]    deg;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              emit_zero;
    logic              clear;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] second_count;
    logic             busy;
    logic             out_full;
  } dp_status_t;

  // Keep the low EFF_BITS of a coefficient, sign-extended to the field width
  function automatic logic signed [COEFF_W-1:0] sext_coeff(
    input logic signed [COEFF_W-1:0] raw
  );
    logic signed [COEFF_W-1:0] up;
    up = raw <<< EXT_SHIFT;
    return up >>> EXT_SHIFT;
  endfunction

endpackage

`default_nettype wire

[design/polynomial_multiply_core.sv]
// Loads: one coefficient request per cycle while no product is being computed.
// Product: after the final coefficient of the second list, each degree k is summed
// term by term on one shared MAC, then the pipeline drains and the sum is handed
// to the output register.
// Synchronous active-high reset empties both lists and drops any pending result.
// Top level; depends on pmc_pkg, pmc_ctrl and pmc_datapath.
`default_nettype none

module polynomial_multiply_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pmc_pkg::in_req_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output pmc_pkg::out_req_t result
);
  import pmc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       item_accept;

  // Input is open only in the load phase
  assign item_stall  = !cmd.load_open;
  assign item_accept = item_valid && !item_stall;

  pmc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_accept (item_accept),
    .item_func   (item.func),
    .item_last   (item.last),
    .status      (status),
    .cmd         (cmd)
  );

  pmc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item_accept  (item_accept),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[design/pmc_ctrl.sv]
// Controller of the polynomial multiply core: load phase, then a walk over
// product degrees and the terms of each degree. Depends on pmc_pkg.
`default_nettype none

module pmc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_accept,
  input  logic               item_func,
  input  logic               item_last,
  input  pmc_pkg::dp_status_t status,
  output pmc_pkg::ctrl_cmd_t  cmd
);
  import pmc_pkg::*;

  pmc_state_t        state;
  pmc_state_t        state_next;
  logic [K_W-1:0]    k;
  logic [ADDR_W-1:0] i_idx;
  logic [ADDR_W-1:0] j_idx;
  logic              first_term;

  logic [TOT_W-1:0]  m_w;
  logic [TOT_W-1:0]  n_w;
  logic [TOT_W-1:0]  k_w;
  logic [TOT_W-1:0]  i_w;
  logic              any_empty;
  logic              term_last;
  logic              deg_last;
  logic              k_below_n;
  logic              slot_free;
  logic              start;

  // Loop bounds from the stored counts
  assign m_w       = TOT_W'(status.first_count);
  assign n_w       = TOT_W'(status.second_count);
  assign k_w       = TOT_W'(k);
  assign i_w       = TOT_W'(i_idx);
  assign any_empty = (m_w == '0) || (n_w == '0);
  assign term_last = (i_w + TOT_W'(1) == m_w) || (j_idx == '0);
  assign deg_last  = (k_w + TOT_W'(2) == m_w + n_w);
  assign k_below_n = k_w < n_w;
  assign slot_free = !status.busy && !status.out_full;
  assign start     = item_accept && item_func && item_last;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (start) state_next = ST_START;
      ST_START: state_next = any_empty ? ST_ZERO : ST_DEG;
      ST_DEG:   if (slot_free) state_next = ST_MAC;
      ST_MAC:   if (term_last) state_next = deg_last ? ST_CLEAR : ST_DEG;
      ST_ZERO:  if (slot_free) state_next = ST_CLEAR;
      ST_CLEAR: if (!status.busy) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    cmd.deg        = k;
    cmd.addr_a     = i_idx;
    cmd.addr_b     = j_idx;
    cmd.first      = first_term;
    cmd.term_last  = term_last;
    cmd.final_term = term_last && deg_last;
    unique case (state)
      ST_LOAD:  cmd.load_open = 1'b1;
      ST_MAC:   cmd.issue     = 1'b1;
      ST_ZERO:  cmd.emit_zero = slot_free;
      ST_CLEAR: cmd.clear     = !status.busy;
      default:  cmd.issue     = 1'b0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Degree and term counters
  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      first_term <= 1'b0;
    end else if (state == ST_START) begin
      k <= '0;
    end else if (state == ST_DEG && slot_free) begin
      // First term of degree k: i = max(0, k-n+1), j = k - i
      first_term <= 1'b1;
      if (k_below_n) begin
        i_idx <= '0;
        j_idx <= ADDR_W'(k);
      end else begin
        i_idx <= ADDR_W'(k_w - n_w + TOT_W'(1));
        j_idx <= ADDR_W'(n_w - TOT_W'(1));
      end
    end else if (state == ST_MAC) begin
      first_term <= 1'b0;
      if (term_last) begin
        k <= k + K_W'(1);
      end else begin
        i_idx <= i_idx + ADDR_W'(1);
        j_idx <= j_idx - ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/pmc_datapath.sv]
// Datapath of the polynomial multiply core: coefficient memories, counts,
// multiply-accumulate pipeline and the output register. Depends on pmc_pkg.
`default_nettype none

module pmc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_accept,
  input  pmc_pkg::in_req_t    item,
  input  pmc_pkg::ctrl_cmd_t  cmd,
  output pmc_pkg::dp_status_t status,
  output logic                result_valid,
  input  logic                result_stall,
  output pmc_pkg::out_req_t   result
);
  import pmc_pkg::*;

  logic signed [COEFF_W-1:0]   first_mem  [MAX_TERMS];
  logic signed [COEFF_W-1:0]   second_mem [MAX_TERMS];
  logic [CNT_W-1:0]            first_count;
  logic [CNT_W-1:0]            second_count;
  logic                        overflow_flag;
  logic                        first_full;
  logic                        second_full;
  logic signed [COEFF_W-1:0]   item_value;
  logic signed [COEFF_W-1:0]   a_rd;
  logic signed [COEFF_W-1:0]   b_rd;

  logic                        v1;
  logic                        first1;
  logic                        last1;
  logic                        fin1;
  logic [K_W-1:0]              deg1;
  logic                        v2;
  logic                        first2;
  logic                        last2;
  logic                        fin2;
  logic [K_W-1:0]              deg2;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SUM_OUT_W-1:0] acc;
  logic signed [SUM_OUT_W-1:0] acc_sum;

  assign item_value  = sext_coeff(item.coeff);
  assign first_full  = first_count == CNT_W'(MAX_TERMS);
  assign second_full = second_count == CNT_W'(MAX_TERMS);

  // Coefficient stores
  always_ff @(posedge clk) begin
    if (item_accept && !item.func && !first_full) begin
      first_mem[first_count[ADDR_W-1:0]] <= item_value;
    end
    if (item_accept && item.func && !second_full) begin
      second_mem[second_count[ADDR_W-1:0]] <= item_value;
    end
  end

  // Registered reads for the MAC pipeline
  always_ff @(posedge clk) begin
    a_rd <= first_mem[cmd.addr_a];
    b_rd <= second_mem[cmd.addr_b];
  end

  // Counts and dropped flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
    end else if (item_accept) begin
      if (!item.func) begin
        if (first_full) begin
          overflow_flag <= 1'b1;
        end else begin
          first_count <= first_count + CNT_W'(1);
        end
      end else begin
        if (second_full) begin
          overflow_flag <= 1'b1;
        end else begin
          second_count <= second_count + CNT_W'(1);
        end
      end
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // Pipeline tags and product
  always_ff @(posedge clk) begin
    first1 <= cmd.first;
    last1  <= cmd.term_last;
    fin1   <= cmd.final_term;
    deg1   <= cmd.deg;
    first2 <= first1;
    last2  <= last1;
    fin2   <= fin1;
    deg2   <= deg1;
    prod   <= a_rd * b_rd;
  end

  // Accumulate; the first term of a degree restarts the sum
  assign acc_sum = first2 ? SUM_OUT_W'(prod) : acc + SUM_OUT_W'(prod);

  always_ff @(posedge clk) begin
    if (v2) begin
      acc <= acc_sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((v2 && last2) || cmd.emit_zero) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && last2) begin
      result.product_coeff <= acc_sum;
      result.degree        <= DEG_W'(deg2);
      result.last_out      <= fin2;
      result.dropped       <= overflow_flag;
    end else if (cmd.emit_zero) begin
      result.product_coeff <= '0;
      result.degree        <= '0;
      result.last_out      <= 1'b1;
      result.dropped       <= overflow_flag;
    end
  end

  // Status
  assign status.first_count  = first_count;
  assign status.second_count = second_count;
  assign status.busy         = v1 || v2;
  assign status.out_full     = result_valid;

endmodule

`default_nettype wire

[design/pmc_checker.sv]
// Port-level checks for the polynomial multiply core, bound to the top level.
// Depends on pmc_pkg and polynomial_multiply_core.
`default_nettype none

module pmc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input pmc_pkg::in_req_t  item,
  input logic              result_valid,
  input logic              result_stall,
  input pmc_pkg::out_req_t result
);
  import pmc_pkg::*;

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Final coefficient of the second list closes the input
  a_start_closes: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.func && item.last |=> item_stall)
    else $error("input open after compute start");

  // Input stays closed while a product is still being delivered
  a_mid_product_closed: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last_out |-> item_stall)
    else $error("input open in the middle of a product");

  // A new result only appears during a compute phase
  a_result_in_compute: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_stall)
    else $error("result appeared during load phase");

endmodule

bind polynomial_multiply_core pmc_checker u_pmc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

[test/pmc_product_checker.sv]
// Checker for the polynomial multiply core: watches both request channels, predicts
// the product coefficients and compares each accepted result request in order.
// Depends on pmc_pkg.
`default_nettype none

module pmc_product_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  pmc_pkg::in_req_t  item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  pmc_pkg::out_req_t result,
  output int                mismatches,
  output int                outstanding
);
  import pmc_pkg::*;

  // Coefficients keep this many low bits, sign-extended
  localparam int     KEEP_BITS = (COEFF_BITS < COEFF_W) ? COEFF_BITS : COEFF_W;
  localparam longint SUM_HI    = (longint'(1) <<< (SUM_OUT_W - 1)) - 1;
  localparam longint SUM_LO    = -(longint'(1) <<< (SUM_OUT_W - 1));
  localparam int     NUM_DEG   = 2 * MAX_TERMS - 1;

  longint   first_list [MAX_TERMS];
  longint   second_list[MAX_TERMS];
  longint   deg_sums   [NUM_DEG];
  int       first_len;
  int       second_len;
  bit       lost_coeff;
  int       fails;
  out_req_t product_due[$];

  function automatic longint narrow_coeff(input logic [COEFF_W-1:0] raw);
    longint v;
    v = longint'(raw) & ((longint'(1) <<< KEEP_BITS) - 1);
    if (v >= (longint'(1) <<< (KEEP_BITS - 1))) v = v - (longint'(1) <<< KEEP_BITS);
    return v;
  endfunction

  // Linear convolution of the two stored lists (one zero if either is empty), then both lists empty
  task automatic convolve_lists();
    int       total;
    longint   s;
    out_req_t r;
    r.dropped = lost_coeff;
    if (first_len == 0 || second_len == 0) begin
      r.product_coeff = '0;
      r.degree        = '0;
      r.last_out      = 1'b1;
      product_due.push_back(r);
    end else begin
      total = first_len + second_len - 1;
      for (int k = 0; k < NUM_DEG; k++) deg_sums[k] = 0;
      for (int i = 0; i < first_len; i++)
        for (int j = 0; j < second_len; j++)
          deg_sums[i + j] += first_list[i] * second_list[j];
      for (int k = 0; k < total; k++) begin
        s = deg_sums[k];
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        r.product_coeff = SUM_OUT_W'(s);
        r.degree        = DEG_W'(k);
        r.last_out      = (k == total - 1);
        product_due.push_back(r);
      end
    end
    first_len  = 0;
    second_len = 0;
    lost_coeff = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    out_req_t want;
    longint   v;
    if (rst) begin
      first_len  = 0;
      second_len = 0;
      lost_coeff = 1'b0;
      fails      = 0;
      product_due.delete();
    end else begin
      // result requests: compare against the oldest prediction
      if (result_valid && !result_stall) begin
        if (product_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: coeff %0d deg %0d last %0b dropped %0b",
                   $time, result.product_coeff, result.degree, result.last_out,
                   result.dropped);
        end else begin
          want = product_due.pop_front();
          if (result !== want) begin
            fails++;
            $display({"%0t: expected coeff %0d deg %0d last %0b dropped %0b, ",
                      "got coeff %0d deg %0d last %0b dropped %0b"},
                     $time, want.product_coeff, want.degree, want.last_out,
                     want.dropped, result.product_coeff, result.degree,
                     result.last_out, result.dropped);
          end
        end
      end
      // coefficient requests: func set selects the second list
      if (item_valid && !item_stall) begin
        v = narrow_coeff(item.coeff);
        if (!item.func) begin
          if (first_len < MAX_TERMS) begin
            first_list[first_len] = v;
            first_len++;
          end else begin
            lost_coeff = 1'b1;
          end
        end else begin
          if (second_len < MAX_TERMS) begin
            second_list[second_len] = v;
            second_len++;
          end else begin
            lost_coeff = 1'b1;
          end
          if (item.last) convolve_lists();
        end
      end
    end
    mismatches  <= fails;
    outstanding <= product_due.size();
  end

endmodule

`default_nettype wire

[test/tb_polynomial_multiply_core.sv]
// Testbench top for the polynomial multiply core: clock, reset, coefficient and
// result-side traffic with random gaps and stalls, and the verdict.
// Depends on pmc_pkg, polynomial_multiply_core and pmc_product_checker.
`default_nettype none

module tb_polynomial_multiply_core;
  import pmc_pkg::*;

  localparam logic LIST_A       = 1'b0;
  localparam logic LIST_B       = 1'b1;
  localparam int   RANDOM_ITEMS = 350;
  localparam int   SETTLE       = 1400;
  localparam int   LIMIT        = 500_000;

  typedef enum int {FILL_ANY, FILL_EDGE, FILL_NEAR} fill_t;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     item_valid   = 1'b0;
  logic     result_stall = 1'b0;
  in_req_t  item         = '0;
  logic     item_stall;
  logic     result_valid;
  out_req_t result;
  int       mismatches;
  int       outstanding;
  int       cycles       = 0;
  int       sent         = 0;
  bit       feed_calm    = 1'b0;
  bit       drain_calm   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polynomial_multiply_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  pmc_product_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall before taking each result, calm stretches between
  initial begin : drain
    int gap;
    forever begin
      if ($urandom_range(0, 15) == 0) drain_calm = !drain_calm;
      gap = drain_calm ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        result_stall <= 1'b1;
      end
      @(negedge clk);
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // One coefficient request; valid stays up across back-to-back requests
  task automatic send_coeff(input logic sel, input logic signed [COEFF_W-1:0] c,
                            input logic fin);
    in_req_t r;
    int      gap;
    r.func  = sel;
    r.coeff = c;
    r.last  = fin;
    if ($urandom_range(0, 15) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    repeat (gap) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [COEFF_W-1:0] pick_coeff(input fill_t fill);
    case (fill)
      FILL_EDGE: return ($urandom_range(0, 3) != 0) ? 16'sh8000 : 16'sh7FFF;
      FILL_NEAR: return COEFF_W'($urandom_range(0, 16) - 8);
      default:   return COEFF_W'($urandom);
    endcase
  endfunction

  // Mostly short lists; now and then one near, at or over capacity
  function automatic int pick_len(input bit allow_empty);
    int r;
    r = $urandom_range(0, 19);
    if (allow_empty && r == 0) return 0;
    if (r <= 1) return $urandom_range(MAX_TERMS - 2, MAX_TERMS + 2);
    return $urandom_range(1, 8);
  endfunction

  // Well-formed pair of lists, interleaved; the final second-list coefficient
  // carries last and starts the product
  task automatic run_product(input int len_a, input int len_b, input fill_t fill);
    int rem_a;
    int rem_b;
    rem_a = len_a;
    rem_b = len_b;
    while (rem_a + rem_b > 0) begin
      if (rem_a > 0 && (rem_b == 1 || $urandom_range(0, 1) == 1)) begin
        send_coeff(LIST_A, pick_coeff(fill), rem_a == 1 || $urandom_range(0, 7) == 0);
        rem_a--;
      end else begin
        send_coeff(LIST_B, pick_coeff(fill), rem_b == 1);
        rem_b--;
      end
    end
  endtask

  // Stray loads with no product behind them; they carry into the next product
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 1) == 1) send_coeff(LIST_B, pick_coeff(FILL_ANY), 1'b0);
      else send_coeff(LIST_A, pick_coeff(FILL_ANY), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    int    start;
    fill_t fill;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // extreme coefficients on both lists
    send_coeff(LIST_A, 16'sh7FFF, 1'b0);
    send_coeff(LIST_A, 16'sh8000, 1'b1);
    send_coeff(LIST_B, 16'sh8000, 1'b0);
    send_coeff(LIST_B, 16'sh7FFF, 1'b1);
    // empty first list gives a single zero
    send_coeff(LIST_B, 16'sh1234, 1'b1);
    // last on the first list only stores; more first-list terms still append
    send_coeff(LIST_A, 16'sd5, 1'b1);
    send_coeff(LIST_A, -16'sd3, 1'b0);
    send_coeff(LIST_B, -16'sd7, 1'b1);
    // single terms
    send_coeff(LIST_A, -16'sd1, 1'b1);
    send_coeff(LIST_B, -16'sd1, 1'b1);
    // interleaved lists with a zero term
    send_coeff(LIST_B, 16'sd2, 1'b0);
    send_coeff(LIST_A, 16'sd3, 1'b0);
    send_coeff(LIST_B, -16'sd4, 1'b0);
    send_coeff(LIST_A, 16'sd0, 1'b1);
    send_coeff(LIST_B, 16'sd1, 1'b1);
    // all bits set on both lists
    send_coeff(LIST_A, 16'shFFFF, 1'b1);
    send_coeff(LIST_B, 16'shFFFF, 1'b1);

    // random products, some noise between them
    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        case ($urandom_range(0, 5))
          0:       fill = FILL_EDGE;
          1:       fill = FILL_NEAR;
          default: fill = FILL_ANY;
        endcase
        run_product(pick_len(1'b1), pick_len(1'b0), fill);
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
